// ----- hdl/dbs_pkg.sv -----
// Shared widths, constants and register indexes for the dual bargraph block.
`timescale 1ns / 1ps

package dbs_pkg;

  localparam int unsigned PosW     = 12;
  localparam int unsigned ReadingW = 16;
  localparam int unsigned CountW   = 24;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [PosW-1:0]     PosMax     = 12'd4095;
  localparam logic [PosW-1:0]     TurnLevel  = 12'd200;
  localparam logic [CountW-1:0]   IdleReset  = 24'd4200;
  localparam logic [CountW-1:0]   SaverReset = 24'd700;
  localparam logic [ReadingW-1:0] ReadingMin = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_OFFSET  = 2'd0,
    CFG_RIGHT_OFFSET = 2'd1,
    CFG_IDLE_FRAMES  = 2'd2,
    CFG_SAVER_FRAMES = 2'd3
  } cfg_index_e;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_FRAME = 1'b1
  } op_e;

endpackage

// ----- hdl/dbs_slew.sv -----
// Target clamping and one-step slew of a single bar toward its target.
`timescale 1ns / 1ps

module dbs_slew (
  input  logic signed [dbs_pkg::ReadingW-1:0] reading_i,
  input  logic        [dbs_pkg::PosW-1:0]     offset_i,
  input  logic        [dbs_pkg::PosW-1:0]     shown_i,
  output logic        [dbs_pkg::PosW-1:0]     next_o
);
  import dbs_pkg::*;

  logic signed [ReadingW+1:0] sum;
  logic        [PosW-1:0]     target;

  assign sum = $signed({{2{reading_i[ReadingW-1]}}, reading_i})
             + $signed({{(ReadingW+2-PosW){1'b0}}, offset_i});

  // Negative sums clamp to an empty bar, anything past full scale saturates.
  always_comb begin
    priority if (sum[ReadingW+1]) begin
      target = '0;
    end else if (sum[ReadingW:PosW] != '0) begin
      target = PosMax;
    end else begin
      target = sum[PosW-1:0];
    end
  end

  always_comb begin
    priority if (shown_i < target) begin
      next_o = shown_i + 1'b1;
    end else if (shown_i > target) begin
      next_o = shown_i - 1'b1;
    end else begin
      next_o = shown_i;
    end
  end

endmodule

// ----- hdl/dual_bargraph_slew_with_screensaver_top.sv -----
// Top level of the dual bargraph driver with slewing bars and screensaver.
`timescale 1ns / 1ps

// Each transfer on the input channel either stores a signed reading for one
// scale (no result) or is a frame tick that gives one result with both bar
// positions and the screensaver flag. One item is taken every cycle unless
// input stalls; a frame result passes the input, then the output register,
// which part the two sides: input stalls only when the first holds a
// frame tick and the second is full and stalling. The user must write
// configuration via a plain write port while the block idles (not enforced).
module dual_bargraph_slew_with_screensaver_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [dbs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [dbs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_op_i,
  input  logic                                in_side_i,
  input  logic signed [dbs_pkg::ReadingW-1:0] in_reading_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [dbs_pkg::PosW-1:0]     out_left_position_o,
  output logic        [dbs_pkg::PosW-1:0]     out_right_position_o,
  output logic                                out_saver_active_o
);
  import dbs_pkg::*;

  // Configuration registers.
  logic [PosW-1:0]   left_offset_q, right_offset_q;
  logic [CountW-1:0] idle_frames_q, saver_frames_q;

  // Input register.
  logic                       s1_valid_q;
  logic                       s1_op_q;
  logic                       s1_side_q;
  logic signed [ReadingW-1:0] s1_reading_q;

  // Block state.
  logic signed [ReadingW-1:0] left_reading_q, right_reading_q;
  logic [PosW-1:0]            left_shown_q, right_shown_q;
  logic [PosW-1:0]            left_shown_d, right_shown_d;
  logic [CountW-1:0]          idle_count_q, idle_count_d;
  logic [CountW-1:0]          saver_count_q, saver_count_d;
  logic                       sweep_dir_q, sweep_dir_d;
  logic                       saver_d;

  // Output register.
  logic            out_valid_q;
  logic [PosW-1:0] out_left_q, out_right_q;
  logic            out_saver_q;

  logic            out_free;
  logic            s1_advance;
  logic            s1_frame;
  logic [PosW-1:0] left_slew, right_slew;
  logic [PosW-1:0] shrink_pos, grow_pos;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_frame   = (s1_op_q == OP_FRAME);
  assign s1_advance = s1_valid_q && (!s1_frame || out_free);
  assign in_stall_o = s1_valid_q && !s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_offset_q  <= '0;
      right_offset_q <= '0;
      idle_frames_q  <= IdleReset;
      saver_frames_q <= SaverReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_LEFT_OFFSET:  left_offset_q  <= cfg_data_i[PosW-1:0];
        CFG_RIGHT_OFFSET: right_offset_q <= cfg_data_i[PosW-1:0];
        CFG_IDLE_FRAMES:  idle_frames_q  <= cfg_data_i[CountW-1:0];
        CFG_SAVER_FRAMES: saver_frames_q <= cfg_data_i[CountW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_op_q      <= in_op_i;
      s1_side_q    <= in_side_i;
      s1_reading_q <= in_reading_i;
    end
  end

  dbs_slew u_left_slew (
    .reading_i (left_reading_q),
    .offset_i  (left_offset_q),
    .shown_i   (left_shown_q),
    .next_o    (left_slew)
  );

  dbs_slew u_right_slew (
    .reading_i (right_reading_q),
    .offset_i  (right_offset_q),
    .shown_i   (right_shown_q),
    .next_o    (right_slew)
  );

  // In a sweep the bar picked by sweep_dir shrinks and the other one grows.
  always_comb begin
    shrink_pos = sweep_dir_q ? right_shown_q : left_shown_q;
    grow_pos   = sweep_dir_q ? left_shown_q  : right_shown_q;
    if (shrink_pos != '0) begin
      shrink_pos = shrink_pos - 1'b1;
    end
    if (grow_pos != PosMax) begin
      grow_pos = grow_pos + 1'b1;
    end
  end

  always_comb begin
    left_shown_d  = left_shown_q;
    right_shown_d = right_shown_q;
    idle_count_d  = idle_count_q;
    saver_count_d = saver_count_q;
    sweep_dir_d   = sweep_dir_q;
    saver_d       = 1'b0;
    priority if (idle_count_q != '0) begin
      idle_count_d  = idle_count_q - 1'b1;
      left_shown_d  = left_slew;
      right_shown_d = right_slew;
    end else if (saver_count_q < saver_frames_q) begin
      saver_d       = 1'b1;
      saver_count_d = saver_count_q + 1'b1;
      if (sweep_dir_q) begin
        left_shown_d  = grow_pos;
        right_shown_d = shrink_pos;
      end else begin
        left_shown_d  = shrink_pos;
        right_shown_d = grow_pos;
      end
      if (shrink_pos == '0 && grow_pos > TurnLevel) begin
        sweep_dir_d = !sweep_dir_q;
      end
    end else begin
      // Closing frame of a run: bars hold and the idle countdown restarts.
      saver_d       = 1'b1;
      idle_count_d  = idle_frames_q;
      saver_count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_reading_q  <= ReadingMin;
      right_reading_q <= ReadingMin;
      left_shown_q    <= '0;
      right_shown_q   <= '0;
      idle_count_q    <= IdleReset;
      saver_count_q   <= '0;
      sweep_dir_q     <= 1'b0;
    end else if (s1_advance) begin
      if (s1_frame) begin
        left_shown_q  <= left_shown_d;
        right_shown_q <= right_shown_d;
        idle_count_q  <= idle_count_d;
        saver_count_q <= saver_count_d;
        sweep_dir_q   <= sweep_dir_d;
      end else if (s1_side_q) begin
        right_reading_q <= s1_reading_q;
      end else begin
        left_reading_q <= s1_reading_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_advance && s1_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_frame) begin
      out_left_q  <= left_shown_d;
      out_right_q <= right_shown_d;
      out_saver_q <= saver_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_left_position_o  = out_left_q;
  assign out_right_position_o = out_right_q;
  assign out_saver_active_o   = out_saver_q;

endmodule
